// ===== src/wpm_pkg.sv =====
// wpm_pkg: shared constants and types for the wildcard pattern matcher.
// Used by the match cells, the carry unit, the top level and the checker.
// No dependencies.
package wpm_pkg;

    // Default pattern store depth
    localparam int MAX_PATTERN_DEF = 64;

    // Wildcard bytes in a pattern
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    // Input word operation codes
    typedef enum logic [1:0] {
        OP_PATTERN = 2'd0,
        OP_TEXT    = 2'd1,
        OP_FINISH  = 2'd2
    } wpm_op_t;

    // Per-word control handed to every cell
    typedef struct packed {
        logic load;       // pattern word accepted
        logic text;       // text word accepted
        logic finish;     // finish word accepted
        logic append_ok;  // pattern word fits in the store
    } wpm_ctrl_t;

endpackage

// ===== src/wpm_cell.sv =====
// wpm_cell: one pattern position; holds its pattern byte and its match bit.
// Takes the match bit of its left neighbor and the star chain carry.
// Depends on wpm_pkg.
module wpm_cell
    import wpm_pkg::*;
#(
    parameter int IDX   = 1,
    parameter int LEN_W = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  wpm_ctrl_t        ctrl,
    input  logic [7:0]       ch,
    input  logic [LEN_W-1:0] len,
    input  logic [LEN_W-1:0] wr_idx,
    input  logic [LEN_W-1:0] start_lsc,
    input  logic             prev_m,
    input  logic             cin,
    output logic             m,
    output logic             gen,
    output logic             prop
);

    localparam logic [LEN_W-1:0] POS = LEN_W'(IDX);

    logic [7:0] pat_reg;
    logic       m_reg;
    logic       m_next;
    logic       active;
    logic       is_star;
    logic       hit;

    // Cell takes part in the match only when it holds a pattern byte
    assign active  = (len >= POS);
    assign is_star = (pat_reg == STAR_BYTE);
    assign hit     = (pat_reg == ch) || (pat_reg == ANY_BYTE) || is_star;

    // Star cells pass the chain on; cells past the pattern end pass it untouched
    assign gen  = active & ((hit & prev_m) | (is_star & m_reg));
    assign prop = ~active | is_star;
    assign m    = m_reg;

    // Store the pattern byte when this position is next in line
    always_ff @(posedge clk)
    begin
        if (ctrl.load && ctrl.append_ok && (wr_idx == POS - LEN_W'(1)))
        begin
            pat_reg <= ch;
        end
    end

    // Load start row or advance on a text word
    always_comb
    begin
        m_next = m_reg;
        if (ctrl.load || ctrl.finish)
        begin
            m_next = (POS <= start_lsc);
        end
        else if (ctrl.text)
        begin
            m_next = active & (gen | (prop & cin));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= 1'b0;
        end
        else
        begin
            m_reg <= m_next;
        end
    end

endmodule

// ===== src/wpm_carry.sv =====
// wpm_carry: resolves the star chain across the cell row with one wide add.
// Carry into each cell is recovered from the sum; carry out is the end bit.
// Depends on wpm_pkg.
module wpm_carry
    import wpm_pkg::*;
#(
    parameter int WIDTH = MAX_PATTERN_DEF
)
(
    input  logic [WIDTH-1:0] gen,
    input  logic [WIDTH-1:0] prop,
    output logic [WIDTH-1:0] cin,
    output logic             cout
);

    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    logic [WIDTH:0]   sum;

    // Carry at each bit is gen | prop & carry below, as in an adder
    assign a    = gen | prop;
    assign b    = gen;
    assign sum  = {1'b0, a} + {1'b0, b};
    assign cin  = sum[WIDTH-1:0] ^ a ^ b;
    assign cout = sum[WIDTH];

endmodule

// ===== src/wildcard_pattern_matcher_unit.sv =====
// wildcard_pattern_matcher_unit: top level of the wildcard pattern matcher.
// Instantiates the row of wpm_cell and the wpm_carry unit; uses wpm_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries op, ch and start_req.
//   op OP_PATTERN appends ch to the stored pattern (start_req clears it first);
//   op OP_TEXT feeds one text byte; op OP_FINISH reports and rearms for a new
//   text. Unused op code 3 is dropped with no effect.
//   Output channel (out_valid / out_stall) carries matched and
//   pattern_overflow, one word per finish.
// Timing:
//   One word per cycle is sustained unless in_stall holds a finish word. The
//   row of MAX_PATTERN cells updates in parallel, the star chain across them
//   resolves through a single MAX_PATTERN-bit add each cycle.
//   A result is registered and shows on out_valid the cycle after the finish
//   word is taken.
// Reset:
//   Clears pattern length, overflow flag and the match row; the pattern bytes
//   themselves are not cleared and are never read before being written.
// Stall:
//   While a result waits under out_stall, pattern and text words still enter;
//   a further finish word is held off with in_stall until the result is taken.
module wildcard_pattern_matcher_unit
    import wpm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] op,
    input  logic [7:0] ch,
    input  logic       start_req,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       matched,
    output logic       pattern_overflow
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_PATTERN);

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] lsc_reg;
    logic [LEN_W-1:0] lsc_next;
    logic             only_reg;
    logic             only_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             row0_reg;
    logic             row0_next;
    logic             end_reg;
    logic             end_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             matched_reg;
    logic             matched_next;
    logic             pov_reg;
    logic             pov_next;

    logic             accept;
    wpm_ctrl_t        ctrl;
    logic [LEN_W-1:0] len_base;
    logic [LEN_W-1:0] lsc_base;
    logic             only_base;
    logic             ovf_base;
    logic [LEN_W-1:0] start_lsc;

    logic [MAX_PATTERN-1:0] m_row;
    logic [MAX_PATTERN-1:0] prev_row;
    logic [MAX_PATTERN-1:0] gen_row;
    logic [MAX_PATTERN-1:0] prop_row;
    logic [MAX_PATTERN-1:0] cin_row;
    logic                   chain_out;

    // Hold off a finish word only while the previous result is stalled
    assign in_stall = out_valid_reg & out_stall & (op == OP_FINISH);
    assign accept   = in_valid & ~in_stall;

    // Decode the accepted word
    assign ctrl.load   = accept & (op == OP_PATTERN);
    assign ctrl.text   = accept & (op == OP_TEXT);
    assign ctrl.finish = accept & (op == OP_FINISH);

    // Start request empties the pattern before the append
    assign len_base       = (start_req) ? '0 : len_reg;
    assign lsc_base       = (start_req) ? '0 : lsc_reg;
    assign only_base      = start_req | only_reg;
    assign ovf_base       = ~start_req & ovf_reg;
    assign ctrl.append_ok = (len_base != FULL_LEN);

    // Pattern bookkeeping and end-of-row bit
    always_comb
    begin
        len_next  = len_reg;
        lsc_next  = lsc_reg;
        only_next = only_reg;
        ovf_next  = ovf_reg;
        row0_next = row0_reg;
        end_next  = end_reg;
        if (ctrl.load)
        begin
            len_next  = len_base;
            lsc_next  = lsc_base;
            only_next = only_base;
            ovf_next  = ovf_base;
            if (ctrl.append_ok)
            begin
                len_next = len_base + LEN_W'(1);
                if (only_base && (ch == STAR_BYTE))
                begin
                    lsc_next = lsc_base + LEN_W'(1);
                end
                else
                begin
                    only_next = 1'b0;
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
            row0_next = 1'b1;
            end_next  = only_next;
        end
        else if (ctrl.text)
        begin
            row0_next = 1'b0;
            end_next  = chain_out;
        end
        else if (ctrl.finish)
        begin
            row0_next = 1'b1;
            end_next  = only_reg;
        end
    end

    // Start row threshold for the cells
    assign start_lsc = (ctrl.load) ? lsc_next : lsc_reg;

    // Output register: load on finish, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        matched_next   = matched_reg;
        pov_next       = pov_reg;
        if (ctrl.finish)
        begin
            out_valid_next = 1'b1;
            matched_next   = end_reg;
            pov_next       = ovf_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            lsc_reg       <= '0;
            only_reg      <= 1'b1;
            ovf_reg       <= 1'b0;
            row0_reg      <= 1'b1;
            end_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            lsc_reg       <= lsc_next;
            only_reg      <= only_next;
            ovf_reg       <= ovf_next;
            row0_reg      <= row0_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        pov_reg     <= pov_next;
    end

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = pov_reg;

    // Row of cells, each fed by its left neighbor
    assign prev_row = {m_row[MAX_PATTERN-2:0], row0_reg};

    for (genvar g = 0; g < MAX_PATTERN; g++)
    begin : g_cell
        wpm_cell #(
            .IDX   (g + 1),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .ch        (ch),
            .len       (len_reg),
            .wr_idx    (len_base),
            .start_lsc (start_lsc),
            .prev_m    (prev_row[g]),
            .cin       (cin_row[g]),
            .m         (m_row[g]),
            .gen       (gen_row[g]),
            .prop      (prop_row[g])
        );
    end

    // Star chain across the row
    wpm_carry #(
        .WIDTH (MAX_PATTERN)
    ) u_carry (
        .gen  (gen_row),
        .prop (prop_row),
        .cin  (cin_row),
        .cout (chain_out)
    );

endmodule

// ===== src/wpm_chk.sv =====
// wpm_chk: port-level checks for the wildcard pattern matcher.
// Bound to wildcard_pattern_matcher_unit; depends on wpm_pkg.
module wpm_chk
    import wpm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] op,
    input logic       out_valid,
    input logic       out_stall,
    input logic       matched,
    input logic       pattern_overflow
);

    // A finish word taken yields a result word next cycle
    a_finish_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (op == OP_FINISH)) |=> out_valid)
        else $error("finish word did not produce a result");

    // Other words never create a result
    a_no_spurious_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !(in_valid && !in_stall && (op == OP_FINISH))) |=> !out_valid)
        else $error("result word without a finish word");

    // Input is held off only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with no pending result");

    // Stalled result word holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(matched) && $stable(pattern_overflow)))
        else $error("stalled result word changed");

endmodule

bind wildcard_pattern_matcher_unit wpm_chk u_wpm_chk (.*);
